// ===== rtl/fw_pkg.sv =====
// shared types and constants of the all-pairs shortest path block
package fw_pkg;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_CLEAR,
		S_DIAG,
		S_RLX_A,
		S_RLX_AW,
		S_RLX_ROW,
		S_MCLR,
		S_MRK_V,
		S_MRK_VW,
		S_MRK_A,
		S_MRK_AW,
		S_MRK_ROW,
		S_DONE
	} state_t;

	localparam logic [1:0] ACT_CLEAR   = 2'd0;
	localparam logic [1:0] ACT_EDGE    = 2'd1;
	localparam logic [1:0] ACT_COMPUTE = 2'd2;
	localparam logic [1:0] ACT_QUERY   = 2'd3;

	localparam logic [1:0] STS_DONE    = 2'd0;
	localparam logic [1:0] STS_DIST    = 2'd1;
	localparam logic [1:0] STS_UNREACH = 2'd2;
	localparam logic [1:0] STS_NEGINF  = 2'd3;

	localparam logic REG_NODE_COUNT = 1'b0;

	localparam logic signed [31:0] UNREACH = 32'sh7fff_ffff;
	localparam logic signed [32:0] SAT_LOW = -33'sd2147483647;

endpackage

// ===== rtl/all_pairs_shortest_path_core.sv =====
// top level of the all-pairs shortest path block with negative-cycle marking
//
// The block holds a MAX_NODES x MAX_NODES matrix of 32-bit distances and a matching
// matrix of undefined marks, both in synchronous memories. Each input item carries
// one action and returns one result item. Add-edge and query items are taken one per
// cycle while the block is idle and the result side does not stall, and pass a single
// read stage ahead of the result register, with forwarding of an edge written at the
// edge where the next item is read. Clear walks the whole store, one entry a cycle.
// Compute with n active nodes runs the diagonal pass, the relaxation (n^2 rows, a row
// cut short when its first hop is unreachable), a mark clear of n^2 entries and the
// marking pass (each node's self distance is read, plus at most n^2 rows).
// After reset a clearing pass over the whole store runs while no item is taken;
// configuration writes are accepted during it. node_count 0 acts as 1 and values
// above MAX_NODES act as MAX_NODES.
module all_pairs_shortest_path_core #(
	parameter int MAX_NODES = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        action,
	input  logic [7:0]        src_node,
	input  logic [7:0]        dst_node,
	input  logic signed [15:0] edge_weight,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        status,
	output logic signed [31:0] distance
);
	import fw_pkg::*;

	localparam int IW = $clog2(MAX_NODES);
	localparam int AW = 2 * IW;

	// configuration
	logic [8:0]  node_count_q;
	logic        cfg_wr;

	// control
	state_t      state_q, state_d;
	logic [IW-1:0] i_q, j_q, v_q;
	logic [AW-1:0] clr_q;
	logic        iss_q;
	logic        p_vld_s1;
	logic [IW-1:0] p_j_s1;
	logic signed [31:0] a_q;

	// edge / query stage
	logic        vld_s1;
	logic [1:0]  act_s1;
	logic [AW-1:0] addr_s1;
	logic        ok_s1;
	logic signed [31:0] w_s1;
	logic        fwd_s1;
	logic signed [31:0] fwdd_s1;

	// output register
	logic        out_vld_q;
	logic [1:0]  status_q;
	logic signed [31:0] distance_q;

	// memory ports
	logic        ra_en, rb_en, dw_en, mr_en, mw_en;
	logic [AW-1:0] ra_addr, rb_addr, dw_addr, mr_addr, mw_addr;
	logic signed [31:0] ra_data, rb_data, dw_data;
	logic        mr_data, mw_data;

	logic [31:0] nc_ext;
	logic [IW-1:0] n_last;
	logic        in_acc, s1_go, out_free, done_emit;
	logic        in_ok;
	logic [AW-1:0] new_addr;
	logic signed [31:0] w_ext, d_old;
	logic        edge_wr;
	logic        row_state, row_done;
	logic        i_last, j_last, v_last;
	logic signed [32:0] relax_sum;
	logic        relax_lt;
	logic signed [31:0] relax_val;
	logic [1:0]  s1_status;
	logic signed [31:0] s1_distance;

	// apb register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_NODE_COUNT) ? {23'd0, node_count_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= 9'd256;
		end else if (cfg_wr && paddr[2] == REG_NODE_COUNT) begin
			node_count_q <= pwdata[8:0];
		end
	end

	// active node count clamped into 1..MAX_NODES, kept as last index
	assign nc_ext = {23'd0, node_count_q};
	always_comb begin
		if (nc_ext == 32'd0) begin
			n_last = '0;
		end else if (nc_ext > 32'(MAX_NODES)) begin
			n_last = IW'(MAX_NODES - 1);
		end else begin
			n_last = IW'(nc_ext - 32'd1);
		end
	end

	assign i_last = (i_q == n_last);
	assign j_last = (j_q == n_last);
	assign v_last = (v_q == n_last);

	// handshake
	assign out_free  = !out_vld_q || !out_stall;
	assign s1_go     = vld_s1 && out_free;
	assign done_emit = (state_q == S_DONE) && out_free;
	assign in_stall  = !((state_q == S_IDLE) && (!vld_s1 || s1_go));
	assign in_acc    = in_valid && !in_stall;

	assign in_ok = (32'(src_node) <= 32'(n_last)) && (32'(dst_node) <= 32'(n_last));
	assign new_addr = {IW'(src_node), IW'(dst_node)};
	assign w_ext = 32'(edge_weight);

	// edge update and query answer in the read stage
	assign d_old = fwd_s1 ? fwdd_s1 : ra_data;
	assign edge_wr = s1_go && (act_s1 == ACT_EDGE) && ok_s1 && (w_s1 < d_old);

	always_comb begin
		s1_status = STS_DONE;
		s1_distance = '0;
		if (act_s1 == ACT_QUERY) begin
			if (!ok_s1) begin
				s1_status = STS_UNREACH;
			end else if (mr_data) begin
				s1_status = STS_NEGINF;
			end else if (d_old == UNREACH) begin
				s1_status = STS_UNREACH;
			end else begin
				s1_status = STS_DIST;
				s1_distance = d_old;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_acc && (action == ACT_EDGE || action == ACT_QUERY)) begin
			vld_s1 <= 1'b1;
		end else if (s1_go) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_s1  <= action;
			addr_s1 <= new_addr;
			// self-loops with positive weight are dropped
			ok_s1   <= in_ok && !(action == ACT_EDGE && src_node == dst_node &&
				edge_weight > 16'sd0);
			w_s1    <= w_ext;
			// the read issued now misses a write done at this same edge
			fwd_s1  <= edge_wr && (addr_s1 == new_addr);
			fwdd_s1 <= w_s1;
		end
	end

	// relaxation sum, saturated at the low end
	assign relax_sum = 33'(a_q) + 33'(rb_data);
	assign relax_lt  = relax_sum < 33'(ra_data);
	assign relax_val = (relax_sum < SAT_LOW) ? 32'(SAT_LOW) : relax_sum[31:0];

	assign row_state = (state_q == S_DIAG) || (state_q == S_RLX_ROW) ||
		(state_q == S_MRK_ROW);
	assign row_done = !iss_q && !p_vld_s1;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_INIT: begin
				if (clr_q == '1) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_acc && action == ACT_CLEAR) state_d = S_CLEAR;
				else if (in_acc && action == ACT_COMPUTE) state_d = S_DIAG;
			end
			S_CLEAR: begin
				if (clr_q == '1) state_d = S_DONE;
			end
			S_DIAG: begin
				if (row_done) state_d = S_RLX_A;
			end
			S_RLX_A: state_d = S_RLX_AW;
			S_RLX_AW: begin
				if (ra_data != UNREACH) state_d = S_RLX_ROW;
				else if (i_last && v_last) state_d = S_MCLR;
				else state_d = S_RLX_A;
			end
			S_RLX_ROW: begin
				if (row_done) state_d = (i_last && v_last) ? S_MCLR : S_RLX_A;
			end
			S_MCLR: begin
				if (i_last && j_last) state_d = S_MRK_V;
			end
			S_MRK_V: state_d = S_MRK_VW;
			S_MRK_VW: begin
				if (ra_data[31]) state_d = S_MRK_A;
				else state_d = v_last ? S_DONE : S_MRK_V;
			end
			S_MRK_A: state_d = S_MRK_AW;
			S_MRK_AW: begin
				if (ra_data != UNREACH) state_d = S_MRK_ROW;
				else if (!i_last) state_d = S_MRK_A;
				else state_d = v_last ? S_DONE : S_MRK_V;
			end
			S_MRK_ROW: begin
				if (row_done) begin
					if (!i_last) state_d = S_MRK_A;
					else state_d = v_last ? S_DONE : S_MRK_V;
				end
			end
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memory commands
	always_comb begin
		ra_en = 1'b0;
		ra_addr = '0;
		rb_en = 1'b0;
		rb_addr = '0;
		dw_en = edge_wr;
		dw_addr = addr_s1;
		dw_data = w_s1;
		mr_en = 1'b0;
		mr_addr = '0;
		mw_en = 1'b0;
		mw_addr = '0;
		mw_data = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				ra_en = in_acc;
				ra_addr = new_addr;
				mr_en = in_acc;
				mr_addr = new_addr;
			end
			S_INIT, S_CLEAR: begin
				dw_en = 1'b1;
				dw_addr = clr_q;
				dw_data = UNREACH;
				mw_en = 1'b1;
				mw_addr = clr_q;
			end
			S_DIAG: begin
				ra_en = iss_q;
				ra_addr = {j_q, j_q};
				dw_en = p_vld_s1 && (ra_data == UNREACH);
				dw_addr = {p_j_s1, p_j_s1};
				dw_data = '0;
			end
			S_RLX_A, S_MRK_A: begin
				ra_en = 1'b1;
				ra_addr = {i_q, v_q};
			end
			S_RLX_ROW: begin
				ra_en = iss_q;
				ra_addr = {i_q, j_q};
				rb_en = iss_q;
				rb_addr = {v_q, j_q};
				dw_en = p_vld_s1 && (rb_data != UNREACH) && relax_lt;
				dw_addr = {i_q, p_j_s1};
				dw_data = relax_val;
			end
			S_MCLR: begin
				mw_en = 1'b1;
				mw_addr = {i_q, j_q};
			end
			S_MRK_V: begin
				ra_en = 1'b1;
				ra_addr = {v_q, v_q};
			end
			S_MRK_ROW: begin
				rb_en = iss_q;
				rb_addr = {v_q, j_q};
				mw_en = p_vld_s1 && (rb_data != UNREACH);
				mw_addr = {i_q, p_j_s1};
				mw_data = 1'b1;
			end
			S_RLX_AW, S_MRK_VW, S_MRK_AW, S_DONE: begin
				ra_en = 1'b0;
			end
			default: begin
				ra_en = 1'b0;
			end
		endcase
	end

	// state and loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			i_q <= '0;
			j_q <= '0;
			v_q <= '0;
			clr_q <= '0;
			iss_q <= 1'b0;
			p_vld_s1 <= 1'b0;
			p_j_s1 <= '0;
		end else begin
			state_q <= state_d;
			p_vld_s1 <= row_state && iss_q;
			p_j_s1 <= j_q;
			if (row_state && iss_q) begin
				j_q <= j_q + IW'(1);
				if (j_last) iss_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						clr_q <= '0;
						i_q <= '0;
						j_q <= '0;
						v_q <= '0;
						iss_q <= (action == ACT_COMPUTE);
					end
				end
				S_INIT, S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
				end
				S_RLX_AW: begin
					j_q <= '0;
					if (ra_data != UNREACH) begin
						iss_q <= 1'b1;
					end else begin
						i_q <= i_last ? '0 : i_q + IW'(1);
						if (i_last) v_q <= v_last ? '0 : v_q + IW'(1);
					end
				end
				S_RLX_ROW: begin
					if (row_done) begin
						j_q <= '0;
						i_q <= i_last ? '0 : i_q + IW'(1);
						if (i_last) v_q <= v_last ? '0 : v_q + IW'(1);
					end
				end
				S_MCLR: begin
					j_q <= j_last ? '0 : j_q + IW'(1);
					if (j_last) i_q <= i_last ? '0 : i_q + IW'(1);
				end
				S_MRK_VW: begin
					i_q <= '0;
					if (!ra_data[31]) v_q <= v_q + IW'(1);
				end
				S_MRK_AW: begin
					j_q <= '0;
					if (ra_data != UNREACH) begin
						iss_q <= 1'b1;
					end else begin
						i_q <= i_last ? '0 : i_q + IW'(1);
						if (i_last) v_q <= v_q + IW'(1);
					end
				end
				S_MRK_ROW: begin
					if (row_done) begin
						j_q <= '0;
						i_q <= i_last ? '0 : i_q + IW'(1);
						if (i_last) v_q <= v_q + IW'(1);
					end
				end
				default: begin
					clr_q <= clr_q;
				end
			endcase
		end
	end

	// a_q holds the first hop d[i][v] for the whole relaxation row
	always_ff @(posedge clk) begin
		if (state_q == S_RLX_AW) begin
			a_q <= ra_data;
		end
	end

	// result register, decoupled from the input side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_go || done_emit) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			status_q <= s1_status;
			distance_q <= s1_distance;
		end else if (done_emit) begin
			status_q <= STS_DONE;
			distance_q <= '0;
		end
	end

	assign out_valid = out_vld_q;
	assign status    = status_q;
	assign distance  = distance_q;

	fw_store #(
		.AW(AW)
	) u_store (
		.clk     (clk),
		.ra_en   (ra_en),
		.ra_addr (ra_addr),
		.ra_data (ra_data),
		.rb_en   (rb_en),
		.rb_addr (rb_addr),
		.rb_data (rb_data),
		.dw_en   (dw_en),
		.dw_addr (dw_addr),
		.dw_data (dw_data),
		.mr_en   (mr_en),
		.mr_addr (mr_addr),
		.mr_data (mr_data),
		.mw_en   (mw_en),
		.mw_addr (mw_addr),
		.mw_data (mw_data)
	);

endmodule

// ===== rtl/fw_store.sv =====
// distance matrix and undefined-mark matrix memories
module fw_store #(
	parameter int AW = 16
) (
	input  logic              clk,
	input  logic              ra_en,
	input  logic [AW-1:0]     ra_addr,
	output logic signed [31:0] ra_data,
	input  logic              rb_en,
	input  logic [AW-1:0]     rb_addr,
	output logic signed [31:0] rb_data,
	input  logic              dw_en,
	input  logic [AW-1:0]     dw_addr,
	input  logic signed [31:0] dw_data,
	input  logic              mr_en,
	input  logic [AW-1:0]     mr_addr,
	output logic              mr_data,
	input  logic              mw_en,
	input  logic [AW-1:0]     mw_addr,
	input  logic              mw_data
);
	logic signed [31:0] dist_mem [2**AW];
	logic               mark_mem [2**AW];

	always_ff @(posedge clk) begin
		if (dw_en) begin
			dist_mem[dw_addr] <= dw_data;
		end
		if (ra_en) begin
			ra_data <= dist_mem[ra_addr];
		end
		if (rb_en) begin
			rb_data <= dist_mem[rb_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (mw_en) begin
			mark_mem[mw_addr] <= mw_data;
		end
		if (mr_en) begin
			mr_data <= mark_mem[mr_addr];
		end
	end

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench of the all-pairs shortest path core
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import fw_pkg::*;

	// the longest clear pass stays well under this limit on idle cycles
	localparam int STALL_LIMIT = 300000;
	localparam int MAXN        = 256;
	localparam int ITEM_GOAL   = 1600;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] distance;
	} answer_t;

	// one row of the directed part: an optional node count write before it,
	// the item, and an answer typed in where it is obvious
	typedef struct {
		int                 cfg;
		logic [1:0]         act;
		logic [7:0]         src;
		logic [7:0]         dst;
		logic signed [15:0] wgt;
		bit                 pin;
		logic [1:0]         st;
		logic signed [31:0] exp_dist;
	} row_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [1:0] action, status;
	logic [7:0] src_node, dst_node;
	logic signed [15:0] edge_weight;
	logic signed [31:0] distance;

	// typed-in answer travelling with the item on the input side
	logic pin_en;
	answer_t pin_ans;

	// shadow of the block: distance store, undefined marks and node count
	int dist_mem[MAXN*MAXN];
	bit mark_mem[MAXN*MAXN];
	logic [8:0] node_cfg;

	answer_t pending_answers[$];
	int fails;
	int items_in;
	int idle_cycles;
	int clears_left;

	all_pairs_shortest_path_core #(.MAX_NODES(MAXN)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .src_node(src_node), .dst_node(dst_node),
		.edge_weight(edge_weight),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .distance(distance)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int active_nodes();
		if (node_cfg == 0)
			return 1;
		if (node_cfg > MAXN)
			return MAXN;
		return int'(node_cfg);
	endfunction

	function automatic void wipe_store();
		for (int k = 0; k < MAXN*MAXN; k++) begin
			dist_mem[k] = UNREACH;
			mark_mem[k] = 1'b0;
		end
	endfunction

	// diagonal fix-up, relaxation in place, then marks of everything that
	// passes through a node with a negative self distance
	function automatic void all_pairs(int n);
		longint s;
		int a;
		int b;
		for (int i = 0; i < n; i++)
			if (dist_mem[i*MAXN+i] == UNREACH)
				dist_mem[i*MAXN+i] = 0;
		for (int v = 0; v < n; v++)
			for (int i = 0; i < n; i++) begin
				a = dist_mem[i*MAXN+v];
				if (a == UNREACH)
					continue;
				for (int j = 0; j < n; j++) begin
					b = dist_mem[v*MAXN+j];
					if (b == UNREACH)
						continue;
					s = longint'(a) + longint'(b);
					if (s < longint'(dist_mem[i*MAXN+j])) begin
						// saturate at the most negative legal distance
						if (s < -64'sd2147483647)
							s = -64'sd2147483647;
						dist_mem[i*MAXN+j] = int'(s);
					end
				end
			end
		for (int i = 0; i < n; i++)
			for (int j = 0; j < n; j++)
				mark_mem[i*MAXN+j] = 1'b0;
		for (int v = 0; v < n; v++) begin
			if (dist_mem[v*MAXN+v] >= 0)
				continue;
			for (int i = 0; i < n; i++) begin
				if (dist_mem[i*MAXN+v] == UNREACH)
					continue;
				for (int j = 0; j < n; j++)
					if (dist_mem[v*MAXN+j] != UNREACH)
						mark_mem[i*MAXN+j] = 1'b1;
			end
		end
	endfunction

	// applies one item to the shadow and returns the answer it gives
	function automatic answer_t shortest_path_answer(logic [1:0] act, logic [7:0] u,
			logic [7:0] v, logic signed [15:0] w);
		answer_t ans;
		int n;
		int k;
		n = active_nodes();
		k = int'(u)*MAXN + int'(v);
		ans.status = STS_DONE;
		ans.distance = '0;
		case (act)
			ACT_CLEAR: begin
				wipe_store();
			end
			ACT_EDGE: begin
				// out of range nodes and positive self-loops leave the store alone
				if (u < n && v < n && !(u == v && w > 0))
					if (int'(w) < dist_mem[k])
						dist_mem[k] = int'(w);
			end
			ACT_COMPUTE: begin
				all_pairs(n);
			end
			default: begin
				if (u >= n || v >= n)
					ans.status = STS_UNREACH;
				else if (mark_mem[k])
					ans.status = STS_NEGINF;
				else if (dist_mem[k] == UNREACH)
					ans.status = STS_UNREACH;
				else begin
					ans.status = STS_DIST;
					ans.distance = dist_mem[k];
				end
			end
		endcase
		return ans;
	endfunction

	// both channels sampled at the edge, before the block updates its outputs
	always @(posedge clk) begin
		answer_t got;
		answer_t want;
		answer_t calc;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				calc = shortest_path_answer(action, src_node, dst_node, edge_weight);
				pending_answers.push_back(pin_en ? pin_ans : calc);
				items_in++;
			end
			if (out_valid && !out_stall) begin
				got.status = status;
				got.distance = distance;
				if (pending_answers.size() == 0) begin
					$error("result item with no item waiting: status %0d distance %0d",
						got.status, got.distance);
					fails++;
				end else begin
					want = pending_answers.pop_front();
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						fails++;
					end
					if (got.distance !== want.distance) begin
						$error("distance: expected %0d, got %0d", want.distance,
							got.distance);
						fails++;
					end
				end
			end
		end
	end

	// watchdog on cycles where neither channel moves an item
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// receiver: free-running stretches, random stall, long stalls, and once a
	// long hold-off so that the block backs up into its input
	initial begin
		bit held;
		int r;
		held = 1'b0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && items_in >= 500) begin
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
				held = 1'b1;
			end
			r = $urandom_range(0, 99);
			if (r < 40) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end else if (r < 90) begin
				repeat ($urandom_range(1, 20)) begin
					out_stall <= ($urandom_range(0, 2) == 0);
					@(posedge clk);
				end
			end else begin
				out_stall <= 1'b1;
				repeat ($urandom_range(5, 40)) @(posedge clk);
			end
		end
	end

	task automatic send(logic [1:0] act, logic [7:0] u, logic [7:0] v,
			logic signed [15:0] w, bit pin, answer_t ans, bit no_gaps);
		int gap;
		gap = no_gaps ? 0 : gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		action <= act;
		src_node <= u;
		dst_node <= v;
		edge_weight <= w;
		pin_en <= pin;
		pin_ans <= ans;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!(in_valid && !in_stall));
	endtask

	// lowers valid and waits until every result item is back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_node_count(logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_NODE_COUNT, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		node_cfg = value[8:0];
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic rnd(logic [1:0] act, logic [7:0] u, logic [7:0] v,
			logic signed [15:0] w, bit no_gaps);
		send(act, u, v, w, 1'b0, '0, no_gaps);
	endtask

	function automatic logic signed [15:0] pick_weight();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 16'($signed($urandom_range(0, 90)) - 20);
		if (r < 60)
			return 16'($signed($urandom_range(0, 400)) - 400);
		if (r < 72) begin
			case ($urandom_range(0, 3))
				0: return -16'sd32768;
				1: return 16'sd32767;
				2: return -16'sd1;
				default: return 16'sd0;
			endcase
		end
		return 16'($urandom);
	endfunction

	// one randomized phase: a node count, then edges, computes and queries
	task automatic random_phase(ref int sent);
		int n;
		int r;
		int cnt;
		bit fast;
		logic [31:0] cfg;
		logic [7:0] u;
		logic [7:0] v;
		r = $urandom_range(0, 99);
		if (r < 70)
			cfg = $urandom_range(2, 10);
		else if (r < 78)
			cfg = $urandom_range(0, 1);
		else if (r < 86)
			cfg = $urandom_range(11, 255);
		else if (r < 93)
			cfg = 256;
		else
			cfg = $urandom_range(257, 511);
		// upper bits beyond the register are junk
		cfg = {$urandom_range(0, 1) ? 23'($urandom) : 23'd0, cfg[8:0]};
		write_node_count(cfg);
		n = active_nodes();
		fast = ($urandom_range(0, 3) == 0);
		if (clears_left > 0 && $urandom_range(0, 7) == 0) begin
			clears_left--;
			rnd(ACT_CLEAR, 8'($urandom), 8'($urandom), 16'($urandom), fast);
			sent++;
		end
		cnt = (n <= 10) ? $urandom_range(n, 3*n + 2) : $urandom_range(10, 40);
		repeat (cnt) begin
			r = $urandom_range(0, 99);
			if (r < 80 && n <= 10) begin
				u = 8'($urandom_range(0, n - 1));
				v = 8'($urandom_range(0, n - 1));
			end else begin
				u = 8'($urandom);
				v = 8'($urandom);
			end
			rnd(ACT_EDGE, u, v, pick_weight(), fast);
			sent++;
		end
		if (n <= 10) begin
			// a long run of computes drives negative cycles into saturation
			cnt = ($urandom_range(0, 9) == 0) ? 18 : $urandom_range(1, 2);
			repeat (cnt) begin
				rnd(ACT_COMPUTE, 8'($urandom), 8'($urandom), 16'($urandom), fast);
				sent++;
			end
			if ($urandom_range(0, 2) == 0) begin
				// edges after compute leave marks in place
				u = 8'($urandom_range(0, n - 1));
				v = 8'($urandom_range(0, n - 1));
				rnd(ACT_EDGE, u, v, pick_weight(), fast);
				sent++;
			end
		end
		cnt = (n <= 10) ? $urandom_range(n, 2*n*n + 2) : $urandom_range(10, 40);
		repeat (cnt) begin
			if ($urandom_range(0, 99) < 85 && n <= 10) begin
				u = 8'($urandom_range(0, n - 1));
				v = 8'($urandom_range(0, n - 1));
			end else begin
				u = 8'($urandom);
				v = 8'($urandom);
			end
			rnd(ACT_QUERY, u, v, 16'($urandom), fast);
			sent++;
		end
		drain();
	endtask

	initial begin
		row_t rows[$];
		answer_t ans;
		int sent;
		fails = 0;
		items_in = 0;
		idle_cycles = 0;
		clears_left = 4;
		sent = 0;
		node_cfg = 9'd256;
		wipe_store();
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		action = ACT_CLEAR;
		src_node = '0;
		dst_node = '0;
		edge_weight = '0;
		pin_en = 1'b0;
		pin_ans = '0;

		// directed rows, starting at the reset node count of 256
		rows = '{
			'{-1, ACT_QUERY,   8'd0,   8'd0,   16'sd0,      1'b1, STS_UNREACH, 0},
			'{-1, ACT_QUERY,   8'd255, 8'd255, -16'sd1,     1'b1, STS_UNREACH, 0},
			'{-1, ACT_EDGE,    8'd255, 8'd0,   -16'sd32768, 1'b1, STS_DONE,    0},
			'{-1, ACT_QUERY,   8'd255, 8'd0,   16'sd0,      1'b1, STS_DIST,    -32768},
			'{-1, ACT_EDGE,    8'd1,   8'd2,   16'sd32767,  1'b0, STS_DONE,    0},
			'{-1, ACT_EDGE,    8'd1,   8'd2,   16'sd100,    1'b0, STS_DONE,    0},
			'{-1, ACT_QUERY,   8'd1,   8'd2,   16'sd0,      1'b1, STS_DIST,    100},
			// positive self-loop is dropped, a zero one is kept
			'{-1, ACT_EDGE,    8'd3,   8'd3,   16'sd5,      1'b0, STS_DONE,    0},
			'{-1, ACT_QUERY,   8'd3,   8'd3,   16'sd0,      1'b1, STS_UNREACH, 0},
			'{-1, ACT_EDGE,    8'd3,   8'd3,   16'sd0,      1'b0, STS_DONE,    0},
			'{-1, ACT_QUERY,   8'd3,   8'd3,   16'sd0,      1'b1, STS_DIST,    0},
			// node count 0 behaves as a single node
			'{0,  ACT_EDGE,    8'd0,   8'd1,   -16'sd7,     1'b0, STS_DONE,    0},
			'{-1, ACT_QUERY,   8'd0,   8'd1,   16'sd0,      1'b1, STS_UNREACH, 0},
			'{-1, ACT_EDGE,    8'd0,   8'd0,   -16'sd1,     1'b0, STS_DONE,    0},
			'{-1, ACT_COMPUTE, 8'd0,   8'd0,   16'sd0,      1'b1, STS_DONE,    0},
			'{-1, ACT_QUERY,   8'd0,   8'd0,   16'sd0,      1'b1, STS_NEGINF,  0},
			// three nodes with a negative cycle through all of them
			'{3,  ACT_EDGE,    8'd0,   8'd1,   16'sd5,      1'b0, STS_DONE,    0},
			'{-1, ACT_EDGE,    8'd1,   8'd2,   -16'sd3,     1'b0, STS_DONE,    0},
			'{-1, ACT_EDGE,    8'd2,   8'd0,   -16'sd4,     1'b0, STS_DONE,    0},
			'{-1, ACT_COMPUTE, 8'd0,   8'd0,   16'sd0,      1'b0, STS_DONE,    0},
			'{-1, ACT_QUERY,   8'd0,   8'd2,   16'sd0,      1'b0, STS_DONE,    0},
			'{-1, ACT_QUERY,   8'd2,   8'd255, 16'sd0,      1'b1, STS_UNREACH, 0},
			'{-1, ACT_CLEAR,   8'd7,   8'd9,   16'sd3,      1'b1, STS_DONE,    0},
			'{-1, ACT_QUERY,   8'd0,   8'd0,   16'sd0,      1'b1, STS_UNREACH, 0}
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].cfg >= 0) begin
				drain();
				write_node_count(32'(rows[i].cfg));
			end
			ans.status = rows[i].st;
			ans.distance = rows[i].exp_dist;
			send(rows[i].act, rows[i].src, rows[i].dst, rows[i].wgt, rows[i].pin, ans, 1'b0);
			sent++;
		end
		drain();

		// the largest node count, written as an overflow value
		write_node_count(32'd511);
		repeat (30) begin
			rnd(ACT_EDGE, 8'($urandom), 8'($urandom), pick_weight(), 1'b0);
			rnd(ACT_QUERY, 8'($urandom), 8'($urandom), 16'($urandom), 1'b0);
			sent += 2;
		end
		drain();

		while (sent < ITEM_GOAL)
			random_phase(sent);

		write_node_count(32'd256);
		drain();
		repeat (20) @(posedge clk);
		if (fails == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
